@@ rtl/bin_pkg.sv @@
package bin_pkg;

	localparam int PALETTE_SIZE = 256;
	localparam int OFS_W = 7;
	localparam int DIST_W = 18;
	localparam logic [DIST_W-1:0] DIST_ALL_ONES = '1;
	localparam logic [7:0] TRANSPARENT_INDEX = 8'd255;

	typedef struct packed {
		logic [7:0] pixel_index;
		logic last_in;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] pixel_out;
		logic was_bright;
		logic last_out;
	} pix_out_t;

	typedef struct packed {
		logic [7:0] pix;
		logic last;
		logic bright;
		logic use_table;
		logic [OFS_W-1:0] ofs;
	} cls_t;

	typedef enum logic [1:0] {
		BLD_SCAN,
		BLD_DRAIN,
		BLD_WRITE,
		BLD_DONE
	} bld_state_t;

	localparam logic [23:0] PALETTE [PALETTE_SIZE] = '{
		24'h000000, 24'h0F0F0F, 24'h1F1F1F, 24'h2F2F2F, 24'h3F3F3F, 24'h4B4B4B, 24'h5B5B5B, 24'h6B6B6B,
		24'h7B7B7B, 24'h8B8B8B, 24'h9B9B9B, 24'hABABAB, 24'hBBBBBB, 24'hCBCBCB, 24'hDBDBDB, 24'hEBEBEB,
		24'h0F0B07, 24'h170F0B, 24'h1F170B, 24'h271B0F, 24'h2F2313, 24'h372B17, 24'h3F2F17, 24'h4B371B,
		24'h533B1B, 24'h5B431F, 24'h634B1F, 24'h6B531F, 24'h73571F, 24'h7B5F23, 24'h836723, 24'h8F6F23,
		24'h0B0B0F, 24'h13131B, 24'h1B1B27, 24'h272733, 24'h2F2F3F, 24'h37374B, 24'h3F3F57, 24'h474767,
		24'h4F4F73, 24'h5B5B7F, 24'h63638B, 24'h6B6B97, 24'h7373A3, 24'h7B7BAF, 24'h8383BB, 24'h8B8BCB,
		24'h000000, 24'h070700, 24'h0B0B00, 24'h131300, 24'h1B1B00, 24'h232300, 24'h2B2B07, 24'h2F2F07,
		24'h373707, 24'h3F3F07, 24'h474707, 24'h4B4B0B, 24'h53530B, 24'h5B5B0B, 24'h63630B, 24'h6B6B0F,
		24'h070000, 24'h0F0000, 24'h170000, 24'h1F0000, 24'h270000, 24'h2F0000, 24'h370000, 24'h3F0000,
		24'h470000, 24'h4F0000, 24'h570000, 24'h5F0000, 24'h670000, 24'h6F0000, 24'h770000, 24'h7F0000,
		24'h131300, 24'h1B1B00, 24'h232300, 24'h2F2B00, 24'h372F00, 24'h433700, 24'h4B3B07, 24'h574307,
		24'h5F4707, 24'h6B4B0B, 24'h77530F, 24'h835713, 24'h8B5B13, 24'h975F1B, 24'hA3631F, 24'hAF6723,
		24'h231307, 24'h2F170B, 24'h3B1F0F, 24'h4B2313, 24'h572B17, 24'h632F1F, 24'h733723, 24'h7F3B2B,
		24'h8F4333, 24'h9F4F33, 24'hAF632F, 24'hBF772F, 24'hCF8F2B, 24'hDFAB27, 24'hEFCB1F, 24'hFFF31B,
		24'h0B0700, 24'h1B1300, 24'h2B230F, 24'h372B13, 24'h47331B, 24'h533723, 24'h633F2B, 24'h6F4733,
		24'h7F533F, 24'h8B5F47, 24'h9B6B53, 24'hA77B5F, 24'hB7876B, 24'hC3937B, 24'hD3A38B, 24'hE3B397,
		24'hAB8BA3, 24'h9F7F97, 24'h937387, 24'h8B677B, 24'h7F5B6F, 24'h775363, 24'h6B4B57, 24'h5F3F4B,
		24'h573743, 24'h4B2F37, 24'h43272F, 24'h371F23, 24'h2B171B, 24'h231313, 24'h170B0B, 24'h0F0707,
		24'hBB739F, 24'hAF6B8F, 24'hA35F83, 24'h975777, 24'h8B4F6B, 24'h7F4B5F, 24'h734353, 24'h6B3B4B,
		24'h5F333F, 24'h532B37, 24'h47232B, 24'h3B1F23, 24'h2F171B, 24'h231313, 24'h170B0B, 24'h0F0707,
		24'hDBC3BB, 24'hCBB3A7, 24'hBFA39B, 24'hAF978B, 24'hA3877B, 24'h977B6F, 24'h876F5F, 24'h7B6353,
		24'h6B5747, 24'h5F4B3B, 24'h533F33, 24'h433327, 24'h372B1F, 24'h271F17, 24'h1B130F, 24'h0F0B07,
		24'h6F837B, 24'h677B6F, 24'h5F7367, 24'h576B5F, 24'h4F6357, 24'h475B4F, 24'h3F5347, 24'h374B3F,
		24'h2F4337, 24'h2B3B2F, 24'h233327, 24'h1F2B1F, 24'h172317, 24'h0F1B13, 24'h0B130B, 24'h070B07,
		24'hFFF31B, 24'hEFDF17, 24'hDBCB13, 24'hCBB70F, 24'hBBA70F, 24'hAB970B, 24'h9B8307, 24'h8B7307,
		24'h7B6307, 24'h6B5300, 24'h5B4700, 24'h4B3700, 24'h3B2B00, 24'h2B1F00, 24'h1B0F00, 24'h0B0700,
		24'h0000FF, 24'h0B0BEF, 24'h1313DF, 24'h1B1BCF, 24'h2323BF, 24'h2B2BAF, 24'h2F2F9F, 24'h2F2F8F,
		24'h2F2F7F, 24'h2F2F6F, 24'h2F2F5F, 24'h2B2B4F, 24'h23233F, 24'h1B1B2F, 24'h13131F, 24'h0B0B0F,
		24'h2B0000, 24'h3B0000, 24'h4B0700, 24'h5F0700, 24'h6F0F00, 24'h7F1707, 24'h931F07, 24'hA3270B,
		24'hB7330F, 24'hC34B1B, 24'hCF632B, 24'hDB7F3B, 24'hE3974F, 24'hE7AB5F, 24'hEFBF77, 24'hF7D38B,
		24'hA77B3B, 24'hB79B37, 24'hC7C337, 24'hE7E357, 24'h7FBFFF, 24'hABE7FF, 24'hD7FFFF, 24'h670000,
		24'h8B0000, 24'hB30000, 24'hD70000, 24'hFF0000, 24'hFFF393, 24'hFFF7C7, 24'hFFFFFF, 24'h9F5B53
	};

endpackage

@@ rtl/bright_index_nearest_remap.sv @@
// After reset the block builds its remap table before it takes any pixel: for each of the
// NUM_BRIGHT bright indices it scores every lower palette color, one candidate per cycle, and
// pix_stall stays high until the build ends. From then on one pixel is taken and one result
// given every cycle while res_stall stays low; each pixel passes through a two-entry queue,
// the remap table read and the output register. Configuration writes are always taken.
module bright_index_nearest_remap #(
	parameter int NUM_BRIGHT = 32
) (
	input logic clk,
	input logic arst_n,
	input logic pix_valid,
	output logic pix_stall,
	input bin_pkg::pix_in_t pix_data,
	output logic res_valid,
	input logic res_stall,
	output bin_pkg::pix_out_t res_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_data
);

	localparam int AW = (NUM_BRIGHT > 1) ? $clog2(NUM_BRIGHT) : 1;
	localparam logic [7:0] FIRST_IDX = 8'(256 - NUM_BRIGHT);

	logic keep_q;
	logic tbl_we, tbl_ready;
	logic [AW-1:0] tbl_waddr, ram_raddr;
	logic [7:0] tbl_wdata, ram_rdata;
	logic q_push, q_pop, q_full, q_nempty;
	bin_pkg::cls_t q_push_data, q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			keep_q <= cfg_data;
		end
	end

	bin_builder #(
		.NUM_BRIGHT(NUM_BRIGHT)
	) u_builder (
		.clk(clk),
		.arst_n(arst_n),
		.tbl_we(tbl_we),
		.tbl_waddr(tbl_waddr),
		.tbl_wdata(tbl_wdata),
		.tbl_ready(tbl_ready)
	);

	bin_ram #(
		.WIDTH(8),
		.DEPTH(NUM_BRIGHT)
	) u_table (
		.clk(clk),
		.we(tbl_we),
		.waddr(tbl_waddr),
		.wdata(tbl_wdata),
		.re(q_pop),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	bin_front #(
		.NUM_BRIGHT(NUM_BRIGHT)
	) u_front (
		.pix_valid(pix_valid),
		.pix_data(pix_data),
		.pix_stall(pix_stall),
		.tbl_ready(tbl_ready),
		.keep_q(keep_q),
		.q_full(q_full),
		.push(q_push),
		.push_data(q_push_data)
	);

	bin_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data(q_push_data),
		.pop(q_pop),
		.full(q_full),
		.nempty(q_nempty),
		.head(q_head)
	);

	bin_back #(
		.AW(AW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_nempty(q_nempty),
		.q_head(q_head),
		.pop(q_pop),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data)
	);

	// The table is written only during the build, and the build never restarts.
	assert property (@(posedge clk) disable iff (!arst_n) tbl_ready |-> !tbl_we)
		else $error("remap table written after the build finished");

	assert property (@(posedge clk) disable iff (!arst_n) tbl_ready |=> tbl_ready)
		else $error("table ready dropped without a reset");

	assert property (@(posedge clk) disable iff (!arst_n) q_full |-> !q_push)
		else $error("transfer pushed into a full queue");

	// A remapped pixel always lands below the bright range.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.was_bright && (res_data.pixel_out >= FIRST_IDX))
		|-> (keep_q && (res_data.pixel_out == bin_pkg::TRANSPARENT_INDEX)))
		else $error("bright pixel left the block with a bright index");

endmodule

@@ rtl/bin_ram.sv @@
module bin_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/bin_builder.sv @@
module bin_builder #(
	parameter int NUM_BRIGHT = 32
) (
	input logic clk,
	input logic arst_n,
	output logic tbl_we,
	output logic [((NUM_BRIGHT > 1) ? $clog2(NUM_BRIGHT) : 1)-1:0] tbl_waddr,
	output logic [7:0] tbl_wdata,
	output logic tbl_ready
);

	localparam int AW = (NUM_BRIGHT > 1) ? $clog2(NUM_BRIGHT) : 1;
	localparam int FIRST_BRIGHT = 256 - NUM_BRIGHT;
	localparam logic [7:0] FIRST_IDX = 8'(FIRST_BRIGHT);
	localparam logic [7:0] LAST_CAND = 8'(FIRST_BRIGHT - 1);
	localparam logic [AW-1:0] LAST_BRIGHT = AW'(NUM_BRIGHT - 1);

	bin_pkg::bld_state_t state_q, state_d;
	logic [AW-1:0] bright_q;
	logic [7:0] cand_q;
	logic [bin_pkg::DIST_W-1:0] best_dist_q;
	logic [7:0] best_idx_q;
	logic issue;

	logic v_s1;
	logic [7:0] cand_s1;
	logic [15:0] sq_r_s1, sq_g_s1, sq_b_s1;

	logic [7:0] src;
	logic [23:0] src_rgb, cand_rgb;
	logic [7:0] dr, dg, db;
	logic [bin_pkg::DIST_W-1:0] dist_sum;

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	assign src = FIRST_IDX + {{(8 - AW){1'b0}}, bright_q};
	assign src_rgb = bin_pkg::PALETTE[src];
	assign cand_rgb = bin_pkg::PALETTE[cand_q];
	assign dr = abs_diff(src_rgb[23:16], cand_rgb[23:16]);
	assign dg = abs_diff(src_rgb[15:8], cand_rgb[15:8]);
	assign db = abs_diff(src_rgb[7:0], cand_rgb[7:0]);
	assign dist_sum = bin_pkg::DIST_W'(sq_r_s1) + bin_pkg::DIST_W'(sq_g_s1)
		+ bin_pkg::DIST_W'(sq_b_s1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bin_pkg::BLD_SCAN: begin
				if (cand_q == LAST_CAND) begin
					state_d = bin_pkg::BLD_DRAIN;
				end
			end
			bin_pkg::BLD_DRAIN: begin
				state_d = bin_pkg::BLD_WRITE;
			end
			bin_pkg::BLD_WRITE: begin
				if (bright_q == LAST_BRIGHT) begin
					state_d = bin_pkg::BLD_DONE;
				end else begin
					state_d = bin_pkg::BLD_SCAN;
				end
			end
			default: begin
				state_d = bin_pkg::BLD_DONE;
			end
		endcase
	end

	always_comb begin
		issue = 1'b0;
		tbl_we = 1'b0;
		tbl_ready = 1'b0;
		case (state_q)
			bin_pkg::BLD_SCAN: issue = 1'b1;
			bin_pkg::BLD_WRITE: tbl_we = 1'b1;
			bin_pkg::BLD_DONE: tbl_ready = 1'b1;
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	assign tbl_waddr = bright_q;
	assign tbl_wdata = best_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bin_pkg::BLD_SCAN;
			bright_q <= '0;
			cand_q <= '0;
			best_dist_q <= bin_pkg::DIST_ALL_ONES;
			best_idx_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1 <= issue;
			if (issue) begin
				cand_q <= cand_q + 8'd1;
			end
			if (tbl_we) begin
				cand_q <= '0;
				best_dist_q <= bin_pkg::DIST_ALL_ONES;
				best_idx_q <= '0;
				if (bright_q != LAST_BRIGHT) begin
					bright_q <= bright_q + AW'(1);
				end
			end else if (v_s1 && (dist_sum < best_dist_q)) begin
				best_dist_q <= dist_sum;
				best_idx_q <= cand_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			cand_s1 <= cand_q;
			sq_r_s1 <= 16'(dr) * 16'(dr);
			sq_g_s1 <= 16'(dg) * 16'(dg);
			sq_b_s1 <= 16'(db) * 16'(db);
		end
	end

endmodule

@@ rtl/bin_front.sv @@
module bin_front #(
	parameter int NUM_BRIGHT = 32
) (
	input logic pix_valid,
	input bin_pkg::pix_in_t pix_data,
	output logic pix_stall,
	input logic tbl_ready,
	input logic keep_q,
	input logic q_full,
	output logic push,
	output bin_pkg::cls_t push_data
);

	localparam logic [7:0] FIRST_IDX = 8'(256 - NUM_BRIGHT);

	logic bright;
	logic [7:0] ofs;

	assign pix_stall = !tbl_ready || q_full;
	assign push = pix_valid && !pix_stall;

	assign bright = pix_data.pixel_index >= FIRST_IDX;
	assign ofs = pix_data.pixel_index - FIRST_IDX;

	always_comb begin
		push_data.pix = pix_data.pixel_index;
		push_data.last = pix_data.last_in;
		push_data.bright = bright;
		push_data.use_table = bright
			&& !(keep_q && (pix_data.pixel_index == bin_pkg::TRANSPARENT_INDEX));
		push_data.ofs = ofs[bin_pkg::OFS_W-1:0];
	end

endmodule

@@ rtl/bin_queue.sv @@
module bin_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input bin_pkg::cls_t push_data,
	input logic pop,
	output logic full,
	output logic nempty,
	output bin_pkg::cls_t head
);

	bin_pkg::cls_t slot_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full = count_q[1];
	assign nempty = count_q != 2'd0;
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/bin_back.sv @@
module bin_back #(
	parameter int AW = 5
) (
	input logic clk,
	input logic arst_n,
	input logic q_nempty,
	input bin_pkg::cls_t q_head,
	output logic pop,
	output logic [AW-1:0] ram_raddr,
	input logic [7:0] ram_rdata,
	output logic res_valid,
	input logic res_stall,
	output bin_pkg::pix_out_t res_data
);

	logic v_s1;
	bin_pkg::cls_t item_s1;
	logic res_valid_q;
	bin_pkg::pix_out_t res_data_q;
	logic move;

	assign move = v_s1 && (!res_valid_q || !res_stall);
	assign pop = q_nempty && (!v_s1 || move);
	assign ram_raddr = q_head.ofs[AW-1:0];
	assign res_valid = res_valid_q;
	assign res_data = res_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				v_s1 <= 1'b1;
			end else if (move) begin
				v_s1 <= 1'b0;
			end
			if (move) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= q_head;
		end
		if (move) begin
			res_data_q.pixel_out <= item_s1.use_table ? ram_rdata : item_s1.pix;
			res_data_q.was_bright <= item_s1.bright;
			res_data_q.last_out <= item_s1.last;
		end
	end

endmodule
